// ===== rtl/stla_pkg.sv =====
// Shared types and constants of the strip and list triangle assembler.
package stla_pkg;

   localparam int IDX_BITS       = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIST_MODE    = 1'd1;

   localparam logic KIND_TRIANGLE = 1'b0;
   localparam logic KIND_ERROR    = 1'b1;

   localparam logic [IDX_BITS-1:0] VERTEX_COUNT_RESET = 16'hFFFF;
   localparam logic [1:0]          GATHER_FULL        = 2'd2;

   typedef struct packed {
      logic [IDX_BITS-1:0] vertex_index;
      logic                end_of_strip;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] corner_a;
      logic [IDX_BITS-1:0] corner_b;
      logic [IDX_BITS-1:0] corner_c;
      logic                out_kind;
   } rsp_type;

endpackage

// ===== rtl/stla_front.sv =====
// Front end: configuration, gathering state and candidate triangle forming.
module stla_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [stla_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [stla_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  accept,
   input  stla_pkg::req_type                     req_item,
   output logic                                  cmd_push,
   output stla_pkg::rsp_type                     cmd_item
);

   logic [stla_pkg::IDX_BITS-1:0] vcount_ff, vcount_in;
   logic                          list_ff, list_in;
   logic [stla_pkg::IDX_BITS-1:0] older_ff, older_in;
   logic [stla_pkg::IDX_BITS-1:0] newer_ff, newer_in;
   logic [1:0]                    count_ff, count_in;
   logic                          odd_ff, odd_in;
   logic                          err_ff, err_in;

   logic [stla_pkg::IDX_BITS-1:0] idx;
   logic                          formed;

   always_comb begin
      vcount_in = vcount_ff;
      list_in   = list_ff;
      if (csr_write) begin
         case (csr_index)
            stla_pkg::CSR_VERTEX_COUNT: vcount_in = csr_wdata[stla_pkg::IDX_BITS-1:0];
            stla_pkg::CSR_LIST_MODE:    list_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      idx      = req_item.vertex_index;
      formed   = (count_ff == stla_pkg::GATHER_FULL);
      older_in = older_ff;
      newer_in = newer_ff;
      count_in = count_ff;
      odd_in   = odd_ff;
      err_in   = err_ff;
      cmd_push = 1'b0;
      cmd_item = '{corner_a: idx, corner_b: newer_ff, corner_c: idx,
                   out_kind: stla_pkg::KIND_TRIANGLE};
      cmd_item.corner_b = newer_ff;
      cmd_item.corner_a = older_ff;
      if (accept && !err_ff) begin
         if (idx >= vcount_ff) begin
            // out of range: report once, latch, drop the gathered indices
            err_in   = 1'b1;
            count_in = 2'd0;
            odd_in   = 1'b0;
            cmd_push = 1'b1;
            cmd_item = '{corner_a: idx, corner_b: '0, corner_c: '0,
                         out_kind: stla_pkg::KIND_ERROR};
         end else begin
            if (list_ff) begin
               odd_in = 1'b0;
               if (formed) begin
                  cmd_push = 1'b1;
                  count_in = 2'd0;
               end else if (count_ff == 2'd1) begin
                  newer_in = idx;
                  count_in = 2'd2;
               end else begin
                  older_in = idx;
                  count_in = 2'd1;
               end
            end else begin
               if (formed) begin
                  cmd_push = 1'b1;
                  // swap the first two corners at odd positions to keep winding
                  if (odd_ff) begin
                     cmd_item.corner_a = newer_ff;
                     cmd_item.corner_b = older_ff;
                  end
               end else begin
                  count_in = count_ff + 2'd1;
               end
               older_in = newer_ff;
               newer_in = idx;
               odd_in   = !odd_ff;
            end
            if (req_item.end_of_strip) begin
               count_in = 2'd0;
               odd_in   = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= stla_pkg::VERTEX_COUNT_RESET;
         list_ff   <= 1'b0;
         older_ff  <= '0;
         newer_ff  <= '0;
         count_ff  <= 2'd0;
         odd_ff    <= 1'b0;
         err_ff    <= 1'b0;
      end else begin
         vcount_ff <= vcount_in;
         list_ff   <= list_in;
         older_ff  <= older_in;
         newer_ff  <= newer_in;
         count_ff  <= count_in;
         odd_ff    <= odd_in;
         err_ff    <= err_in;
      end
   end

   a_err_sticky : assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("sticky error cleared without reset");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("gathered count beyond two");

   a_list_parity : assert property (@(posedge clock) disable iff (reset)
      (accept && list_ff && !err_ff) |=> !odd_ff)
      else $error("parity set in list mode");

endmodule

// ===== rtl/stla_queue.sv =====
// Short command queue between the front end and the back end.
module stla_queue #(
   parameter int DEPTH = stla_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stla_pkg::rsp_type push_item,
   output logic              full,
   input  logic              pop,
   output stla_pkg::rsp_type pop_item,
   output logic              empty
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] DEPTH_CNT = COUNT_BITS'(DEPTH);
   localparam logic [PTR_BITS-1:0]   PTR_ONE   = PTR_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   stla_pkg::rsp_type      mem_ff [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

endmodule

// ===== rtl/stla_back.sv =====
// Back end: degenerate triangle filter and result output register.
module stla_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  stla_pkg::rsp_type cmd_item,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output stla_pkg::rsp_type rsp_item
);

   logic              valid_ff, valid_in;
   stla_pkg::rsp_type data_ff, data_in;
   logic              degen;
   logic              room;

   always_comb begin
      degen = (cmd_item.out_kind == stla_pkg::KIND_TRIANGLE) &&
              ((cmd_item.corner_a == cmd_item.corner_b) ||
               (cmd_item.corner_b == cmd_item.corner_c) ||
               (cmd_item.corner_a == cmd_item.corner_c));
      room     = !valid_ff || rsp_pop;
      // drop degenerates right away, forward the rest when the register frees
      cmd_pop  = !cmd_empty && (degen || room);
      valid_in = valid_ff && !rsp_pop;
      data_in  = data_ff;
      if (cmd_pop && !degen) begin
         valid_in = 1'b1;
         data_in  = cmd_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_item  = data_ff;

endmodule

// ===== rtl/strip_list_triangle_assembler_core.sv =====
// Top level of the strip and list triangle assembler.
//
//   channel  ports                          direction  moves
//   request  req_push, req_full, req_item   in         one vertex index + end flag
//   result   rsp_pop, rsp_empty, rsp_item   out        one triangle or error
//   csr      csr_write, csr_index, csr_wdata in        vertex count, list mode
//
// One request is taken every cycle while the command queue has room; a
// request reaches the result ports through a queue entry, written at its
// accepting edge, and then the output register.
// Reset (synchronous, active high) restores vertex count 65535, strip mode,
// empty gathering state and a clear error flag.
// A stalled result holds in the output register while the queue keeps
// absorbing requests; req_full rises only once QUEUE_DEPTH commands wait.
module strip_list_triangle_assembler_core #(
   parameter int QUEUE_DEPTH = stla_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [stla_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [stla_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  stla_pkg::req_type                    req_item,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output stla_pkg::rsp_type                    rsp_item
);

   logic              accept;
   logic              cmd_push;
   stla_pkg::rsp_type cmd_push_item;
   logic              cmd_full;
   logic              cmd_pop;
   logic              cmd_empty;
   stla_pkg::rsp_type cmd_pop_item;

   // take a request whenever the queue can hold whatever it might produce
   assign accept   = req_push && !cmd_full;
   assign req_full = cmd_full;

   // front: track the strip or list, form candidate triangles and errors
   stla_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .req_item  (req_item),
      .cmd_push  (cmd_push),
      .cmd_item  (cmd_push_item)
   );

   // decouple the front from output stalls
   stla_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_item (cmd_push_item),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_item  (cmd_pop_item),
      .empty     (cmd_empty)
   );

   // back: drop degenerate triangles, hold the oldest result for the consumer
   stla_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_item  (cmd_pop_item),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
